/* rtl/kdslp_pkg.sv */
// ----------------------------------------------------------------------------
// kdslp_pkg
// shared types and constants for the two-key debouncer with short and long
// press detection
// ----------------------------------------------------------------------------
package kdslp_pkg;

   // function codes of an input word
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // debounced key codes
   localparam logic [1:0] KEY_NONE = 2'd0;
   localparam logic [1:0] KEY_ONE  = 2'd1;
   localparam logic [1:0] KEY_TWO  = 2'd2;

   // event codes
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_K1_SHORT = 3'd1;
   localparam logic [2:0] EV_K1_LONG  = 3'd2;
   localparam logic [2:0] EV_K2_SHORT = 3'd3;
   localparam logic [2:0] EV_K2_LONG  = 3'd4;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TICKS   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS_TICKS = 1'd1;

   // configuration reset values
   localparam logic [3:0] DEBOUNCE_TICKS_RESET   = 4'd3;
   localparam logic [7:0] LONG_PRESS_TICKS_RESET = 8'd100;

   // hold counter saturation value
   localparam logic [7:0] HOLD_TICKS_MAX = 8'hFF;

   typedef struct packed {
      logic func;
      logic key_one_down;
      logic key_two_down;
   } item_type;

   typedef struct packed {
      logic [2:0] event_code;
      logic [1:0] stable_key;
   } result_type;

   typedef struct packed {
      logic       write_enable;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  write_data;
   } csr_write_type;

endpackage

/* rtl/kdslp_in_stage.sv */
// ----------------------------------------------------------------------------
// kdslp_in_stage
// input register: holds one accepted word until the core takes it
// ----------------------------------------------------------------------------
module kdslp_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  kdslp_pkg::item_type req_item,
   output logic                req_stall,
   input  logic                take,
   output logic                item_valid,
   output kdslp_pkg::item_type item
);

   logic                valid_ff;
   logic                valid_in;
   kdslp_pkg::item_type item_ff;
   logic                accept;

   // full and not draining this cycle
   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* rtl/kdslp_core.sv */
// ----------------------------------------------------------------------------
// kdslp_core
// debounce, hold counting and event state; computes one result per word
// ----------------------------------------------------------------------------
module kdslp_core (
   input  logic                     clock,
   input  logic                     reset,
   input  kdslp_pkg::csr_write_type csr,
   input  logic                     advance,
   input  kdslp_pkg::item_type      item,
   output kdslp_pkg::result_type    result
);

   logic [3:0] debounce_ticks_ff;
   logic [7:0] long_press_ticks_ff;

   logic [3:0] disagree_ff;
   logic [3:0] disagree_in;
   logic [1:0] stable_ff;
   logic [1:0] stable_in;
   logic [1:0] previous_ff;
   logic [1:0] previous_in;
   logic [7:0] hold_ff;
   logic [7:0] hold_in;
   logic       long_seen_ff;
   logic       long_seen_in;
   logic [2:0] pending_ff;
   logic [2:0] pending_in;

   logic [1:0] sample;
   logic [3:0] disagree_inc;
   logic [7:0] hold_inc;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff   <= kdslp_pkg::DEBOUNCE_TICKS_RESET;
         long_press_ticks_ff <= kdslp_pkg::LONG_PRESS_TICKS_RESET;
      end else if (csr.write_enable) begin
         case (csr.index)
            kdslp_pkg::CSR_DEBOUNCE_TICKS: begin
               debounce_ticks_ff <= csr.write_data[3:0];
            end
            kdslp_pkg::CSR_LONG_PRESS_TICKS: begin
               long_press_ticks_ff <= csr.write_data[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      sample = kdslp_pkg::KEY_NONE;
      if (item.key_one_down) begin
         sample = kdslp_pkg::KEY_ONE;
      end else if (item.key_two_down) begin
         sample = kdslp_pkg::KEY_TWO;
      end
      disagree_inc = disagree_ff + 4'd1;
      hold_inc     = (hold_ff != kdslp_pkg::HOLD_TICKS_MAX) ? hold_ff + 8'd1 : hold_ff;

      disagree_in  = disagree_ff;
      stable_in    = stable_ff;
      previous_in  = previous_ff;
      hold_in      = hold_ff;
      long_seen_in = long_seen_ff;
      pending_in   = pending_ff;
      result.event_code = kdslp_pkg::EV_NONE;

      if (item.func == kdslp_pkg::FUNC_READ) begin
         result.event_code = pending_ff;
         pending_in        = kdslp_pkg::EV_NONE;
      end else begin
         // debounce
         if (sample == stable_ff) begin
            disagree_in = 4'd0;
         end else if (disagree_inc >= debounce_ticks_ff) begin
            disagree_in = 4'd0;
            stable_in   = sample;
         end else begin
            disagree_in = disagree_inc;
         end

         // press, hold and release
         if (stable_in != kdslp_pkg::KEY_NONE && previous_ff == kdslp_pkg::KEY_NONE) begin
            hold_in      = 8'd0;
            long_seen_in = 1'b0;
         end else if (stable_in != kdslp_pkg::KEY_NONE) begin
            hold_in = hold_inc;
            if (hold_inc >= long_press_ticks_ff && !long_seen_ff) begin
               long_seen_in = 1'b1;
               pending_in   = (stable_in == kdslp_pkg::KEY_ONE) ?
                              kdslp_pkg::EV_K1_LONG : kdslp_pkg::EV_K2_LONG;
            end
         end else if (previous_ff != kdslp_pkg::KEY_NONE) begin
            if (!long_seen_ff) begin
               pending_in = (previous_ff == kdslp_pkg::KEY_ONE) ?
                            kdslp_pkg::EV_K1_SHORT : kdslp_pkg::EV_K2_SHORT;
            end
            hold_in      = 8'd0;
            long_seen_in = 1'b0;
         end
         previous_in = stable_in;
      end

      result.stable_key = stable_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disagree_ff  <= 4'd0;
         stable_ff    <= kdslp_pkg::KEY_NONE;
         previous_ff  <= kdslp_pkg::KEY_NONE;
         hold_ff      <= 8'd0;
         long_seen_ff <= 1'b0;
         pending_ff   <= kdslp_pkg::EV_NONE;
      end else if (advance) begin
         disagree_ff  <= disagree_in;
         stable_ff    <= stable_in;
         previous_ff  <= previous_in;
         hold_ff      <= hold_in;
         long_seen_ff <= long_seen_in;
         pending_ff   <= pending_in;
      end
   end

endmodule

/* rtl/kdslp_out_stage.sv */
// ----------------------------------------------------------------------------
// kdslp_out_stage
// result register: holds a finished word until the consumer takes it
// ----------------------------------------------------------------------------
module kdslp_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  kdslp_pkg::result_type result,
   output logic                  ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output kdslp_pkg::result_type rsp_result
);

   logic                  valid_ff;
   logic                  valid_in;
   kdslp_pkg::result_type result_ff;

   // free, or emptying this cycle
   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

/* rtl/key_debounce_short_long_press_top.sv */
// ----------------------------------------------------------------------------
// key_debounce_short_long_press_top
// two-key debouncer with short and long press events
// ----------------------------------------------------------------------------
// Each input word is either a tick carrying one sample of two keys (key 1
// wins when both are down) or a read that returns and clears the sticky
// event. One result word comes back per input word: the event code (nonzero
// only on a read) and the debounced key after that word. A word is taken
// into an input register, run through the combinational debounce and hold
// logic, and lands in a result register; one word is accepted every cycle,
// and rsp_valid rises once the word has moved from the input register to
// the result register. The only limit on rate is the consumer: while the
// result register is stalled the input register fills and then req_stall
// rises. Configuration writes (debounce_ticks at index 0,
// long_press_ticks at index 1) take effect at the next clock edge and
// belong in idle periods.
// ----------------------------------------------------------------------------
module key_debounce_short_long_press_top (
   input  logic                             clock,
   input  logic                             reset,
   // configuration port
   input  logic                             csr_write_enable,
   input  logic [kdslp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kdslp_pkg::CSR_DATA_W-1:0]  csr_write_data,
   // input channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_func,
   input  logic                             req_key_one_down,
   input  logic                             req_key_two_down,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_event_code,
   output logic [1:0]                       rsp_stable_key
);

   kdslp_pkg::item_type      req_item;
   kdslp_pkg::item_type      item;
   logic                     item_valid;
   kdslp_pkg::result_type    result;
   kdslp_pkg::result_type    rsp_result;
   kdslp_pkg::csr_write_type csr;
   logic                     out_ready;
   logic                     advance;

   assign req_item.func         = req_func;
   assign req_item.key_one_down = req_key_one_down;
   assign req_item.key_two_down = req_key_two_down;

   assign csr.write_enable = csr_write_enable;
   assign csr.index        = csr_index;
   assign csr.write_data   = csr_write_data;

   // a word moves from the input register to the result register, and
   // updates the key state, when both sides allow it
   assign advance = item_valid && out_ready;

   kdslp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_item   (req_item),
      .req_stall  (req_stall),
      .take       (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   kdslp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   kdslp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .ready      (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_event_code = rsp_result.event_code;
   assign rsp_stable_key = rsp_result.stable_key;

endmodule

/* test/key_debounce_short_long_press_top_tb.sv */
// ----------------------------------------------------------------------------
// key_debounce_short_long_press_top_tb
// self-checking bench for the two-key debouncer with short and long press
// events: a scoreboard class tracks debounce, hold count and the sticky event
// for every accepted word, and plain tasks drive press sequences, contact
// bounce and reads under random gaps and stalls over a range of register
// settings
// ----------------------------------------------------------------------------
module key_debounce_short_long_press_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kdslp_pkg::*;

   // tracks the debouncer state and holds the result words still owed
   class key_event_scoreboard;
      logic [3:0] debounce_ticks;
      logic [7:0] long_press_ticks;
      logic [3:0] disagree_count;
      logic [1:0] stable_code;
      logic [1:0] previous_code;
      logic [7:0] hold_ticks;
      logic       long_seen;
      logic [2:0] pending_event;
      result_type expected_words[$];
      int         failures;

      function new();
         debounce_ticks   = DEBOUNCE_TICKS_RESET;
         long_press_ticks = LONG_PRESS_TICKS_RESET;
         disagree_count   = '0;
         stable_code      = KEY_NONE;
         previous_code    = KEY_NONE;
         hold_ticks       = '0;
         long_seen        = 1'b0;
         pending_event    = EV_NONE;
         failures         = 0;
      endfunction

      function void set_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
         if (index == CSR_DEBOUNCE_TICKS)
            debounce_ticks = value[3:0];
         else if (index == CSR_LONG_PRESS_TICKS)
            long_press_ticks = value;
      endfunction

      function void run_tick(input logic [1:0] key_code);
         if (key_code == stable_code) begin
            disagree_count = '0;
         end else begin
            disagree_count = disagree_count + 4'd1;
            if (disagree_count >= debounce_ticks) begin
               disagree_count = '0;
               stable_code    = key_code;
            end
         end

         if (stable_code != KEY_NONE && previous_code == KEY_NONE) begin
            hold_ticks = '0;
            long_seen  = 1'b0;
         end else if (stable_code != KEY_NONE) begin
            // held, or moved straight to the other key
            if (hold_ticks != HOLD_TICKS_MAX)
               hold_ticks = hold_ticks + 8'd1;
            if (hold_ticks >= long_press_ticks && !long_seen) begin
               long_seen     = 1'b1;
               pending_event = (stable_code == KEY_ONE) ? EV_K1_LONG : EV_K2_LONG;
            end
         end else if (previous_code != KEY_NONE) begin
            if (!long_seen)
               pending_event = (previous_code == KEY_ONE) ? EV_K1_SHORT : EV_K2_SHORT;
            hold_ticks = '0;
            long_seen  = 1'b0;
         end

         previous_code = stable_code;
      endfunction

      function void note_word(input item_type w);
         result_type want;
         want.event_code = EV_NONE;
         if (w.func == FUNC_READ) begin
            want.event_code = pending_event;
            pending_event   = EV_NONE;
         end else if (w.key_one_down) begin
            run_tick(KEY_ONE);
         end else if (w.key_two_down) begin
            run_tick(KEY_TWO);
         end else begin
            run_tick(KEY_NONE);
         end
         want.stable_key = stable_code;
         expected_words.push_back(want);
      endfunction

      function void check_word(input result_type got);
         result_type want;
         if (expected_words.size() == 0) begin
            $display("%0t: result word with none expected: event_code %0d stable_key %0d",
                     $time, got.event_code, got.stable_key);
            failures++;
            return;
         end
         want = expected_words.pop_front();
         if (got.event_code !== want.event_code) begin
            $display("%0t: event_code mismatch: expected %0d, actual %0d",
                     $time, want.event_code, got.event_code);
            failures++;
         end
         if (got.stable_key !== want.stable_key) begin
            $display("%0t: stable_key mismatch: expected %0d, actual %0d",
                     $time, want.stable_key, got.stable_key);
            failures++;
         end
      endfunction

      function void check_leftover();
         if (expected_words.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time,
                     expected_words.size());
            failures++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_func;
   logic                   req_key_one_down;
   logic                   req_key_two_down;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [2:0]             rsp_event_code;
   logic [1:0]             rsp_stable_key;

   key_event_scoreboard sb = new();

   // when set, neither side idles
   bit quiet = 1'b0;
   int words_sent = 0;
   int stall_left = 0;

   // settings swept after the directed part; the last phases are random
   int phase_debounce[7] = '{0, 15, 1, 3, 2, 15, 0};
   int phase_long[7]     = '{0, 255, 1, 100, 10, 0, 255};

   key_debounce_short_long_press_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_key_one_down (req_key_one_down),
      .req_key_two_down (req_key_two_down),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_code   (rsp_event_code),
      .rsp_stable_key   (rsp_stable_key)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // random bit for don't-care keys and bounce
   function automatic logic coin();
      return logic'($urandom_range(0, 1));
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   // one input word; called and returns at a falling edge
   task automatic send_word(input logic func, input logic k1, input logic k2);
      int       gap;
      item_type w;
      gap            = pick_gap();
      w.func         = func;
      w.key_one_down = k1;
      w.key_two_down = k2;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_key_one_down <= k1;
      req_key_two_down <= k2;
      // word is taken at the first rising edge without stall
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_word(w);
      words_sent++;
      @(negedge clock);
   endtask

   // register write, only while the block is idle
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.set_register(index, value);
      @(negedge clock);
   endtask

   // wait until every owed result word has been checked, then idle
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.expected_words.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // a burst of arbitrary words, reads and ticks mixed
   task automatic send_noise();
      repeat ($urandom_range(1, 8))
         send_word(coin(), coin(), coin());
   endtask

   // one press: bounce in, hold (maybe moving to the other key), bounce out,
   // then usually a read of the event
   task automatic play_press(input int deb, input int lp);
      int eff_deb;
      int n;
      int switch_at;
      int i;
      int pick;
      int r;
      eff_deb = (deb == 0) ? 1 : deb;
      pick    = $urandom_range(0, 1);
      repeat ($urandom_range(0, 3))
         send_word(FUNC_TICK, coin(), coin());
      case ($urandom_range(0, 9))
         0, 1, 2:    n = $urandom_range(0, eff_deb + 2);
         3, 4, 5, 6: n = lp + $urandom_range(0, 2 * eff_deb + 6) - 3;
         7, 8:       n = eff_deb + $urandom_range(0, lp);
         default:    n = eff_deb + 256 + $urandom_range(0, 20);
      endcase
      if (n < 0)
         n = 0;
      switch_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n) : -1;
      for (i = 0; i < n; i++) begin
         if (i == switch_at)
            pick = 1 - pick;
         r = $urandom_range(0, 99);
         if (r < 6)
            send_word(FUNC_READ, coin(), coin());
         else if (r < 10)
            send_word(FUNC_TICK, coin(), coin());
         else if (pick == 0)
            send_word(FUNC_TICK, 1'b1, coin());
         else
            send_word(FUNC_TICK, 1'b0, 1'b1);
      end
      repeat (eff_deb + $urandom_range(1, 4)) begin
         if ($urandom_range(0, 99) < 8)
            send_word(FUNC_TICK, coin(), coin());
         else
            send_word(FUNC_TICK, 1'b0, 1'b0);
      end
      if ($urandom_range(0, 9) < 7)
         send_word(FUNC_READ, coin(), coin());
   endtask

   // result side: stall pattern changes at the falling edge
   initial begin
      rsp_stall = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (stall_left == 0)
            stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result words are checked where they are taken
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word(result_type'({rsp_event_code, rsp_stable_key}));
   end

   initial begin
      int         phase;
      int         phase_end;
      logic [3:0] deb;
      logic [7:0] lp;

      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_DEBOUNCE_TICKS;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_func         = FUNC_TICK;
      req_key_one_down = 1'b0;
      req_key_two_down = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part: fast settings so each case shows in a few words
      quiet = 1'b1;
      write_register(CSR_DEBOUNCE_TICKS, 8'd1);
      write_register(CSR_LONG_PRESS_TICKS, 8'd3);
      send_word(FUNC_READ, 1'b1, 1'b1);   // read with nothing pending, keys ignored
      send_word(FUNC_TICK, 1'b1, 1'b0);   // key 1 press
      send_word(FUNC_TICK, 1'b1, 1'b0);
      send_word(FUNC_TICK, 1'b1, 1'b0);
      send_word(FUNC_TICK, 1'b1, 1'b0);   // threshold reached, key 1 long
      send_word(FUNC_READ, 1'b0, 1'b0);   // returns the long event
      send_word(FUNC_READ, 1'b0, 1'b1);   // cleared by the read before
      send_word(FUNC_TICK, 1'b0, 1'b0);   // release after long, no short
      send_word(FUNC_TICK, 1'b0, 1'b1);   // key 2 press
      send_word(FUNC_TICK, 1'b0, 1'b0);   // quick release, key 2 short
      send_word(FUNC_READ, 1'b1, 1'b0);   // keys on a read change nothing
      send_word(FUNC_TICK, 1'b1, 1'b1);   // both down counts as key 1
      send_word(FUNC_TICK, 1'b0, 1'b1);   // straight to key 2, hold goes on
      send_word(FUNC_TICK, 1'b0, 1'b1);
      send_word(FUNC_TICK, 1'b0, 1'b1);   // long event under key 2
      send_word(FUNC_TICK, 1'b0, 1'b0);
      send_word(FUNC_READ, 1'b0, 1'b0);
      send_word(FUNC_TICK, 1'b1, 1'b0);   // two short presses, second overwrites
      send_word(FUNC_TICK, 1'b0, 1'b0);
      send_word(FUNC_TICK, 1'b0, 1'b1);
      send_word(FUNC_TICK, 1'b0, 1'b0);
      send_word(FUNC_READ, 1'b1, 1'b1);
      drain_results();

      // random part, one phase per register setting
      for (phase = 0; phase < 10; phase++) begin
         if (phase < 7) begin
            deb = 4'(phase_debounce[phase]);
            lp  = 8'(phase_long[phase]);
         end else begin
            deb = 4'($urandom_range(0, 15));
            lp  = 8'($urandom_range(0, 255));
         end
         write_register(CSR_DEBOUNCE_TICKS, {4'd0, deb});
         write_register(CSR_LONG_PRESS_TICKS, lp);
         phase_end = words_sent + 150;
         while (words_sent < phase_end) begin
            // occasional stretches with no idling on either side
            quiet = ($urandom_range(0, 6) == 0);
            if ($urandom_range(0, 4) == 0)
               send_noise();
            else
               play_press(deb, lp);
         end
         quiet = 1'b0;
         drain_results();
      end

      repeat (8) @(negedge clock);
      sb.check_leftover();
      if (sb.failures == 0)
         $display("key_debounce_short_long_press_top test passed");
      else
         $display("key_debounce_short_long_press_top test failed");
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #(30_000_000);
      $display("key_debounce_short_long_press_top test failed");
      $finish;
   end

endmodule

/* sim.f */
rtl/kdslp_pkg.sv
rtl/kdslp_in_stage.sv
rtl/kdslp_core.sv
rtl/kdslp_out_stage.sv
rtl/key_debounce_short_long_press_top.sv
test/key_debounce_short_long_press_top_tb.sv
